>>> design/ardp_pkg.sv
// Shared types and constants for the ATA return descriptor parser.
package ardp_pkg;

	// Sense data positions are counted in eight bits
	localparam int unsigned POS_W = 8;
	// Descriptor list offsets wrap at nine bits
	localparam int unsigned OFF_W = 9;
	localparam int unsigned LBA_W = 48;

	// Response code check
	localparam logic [7:0] RESP_CODE_MASK = 8'h7F;
	localparam logic [7:0] RESP_CODE_CUR  = 8'h72;
	localparam logic [7:0] RESP_CODE_DEF  = 8'h73;

	// Descriptor walk
	localparam logic [OFF_W-1:0] FIRST_DESC_OFF = 9'd8;
	localparam logic [7:0]       ATA_DESC_CODE  = 8'h09;
	localparam logic [7:0]       ATA_DESC_MINLEN = 8'h0C;

	// Byte offsets inside the ATA return descriptor
	localparam logic [7:0] OFF_ERROR    = 8'd3;
	localparam logic [7:0] OFF_LBA_HI_C = 8'd6;
	localparam logic [7:0] OFF_LBA_LO   = 8'd7;
	localparam logic [7:0] OFF_LBA_HI_X = 8'd8;
	localparam logic [7:0] OFF_LBA_MID  = 8'd9;
	localparam logic [7:0] OFF_LBA_TOP  = 8'd10;
	localparam logic [7:0] OFF_LBA_HIGH = 8'd11;
	localparam logic [7:0] OFF_STATUS   = 8'd13;

	// One parse result
	typedef struct packed {
		logic             found;
		logic [7:0]       status;
		logic [7:0]       error;
		logic [LBA_W-1:0] lba;
	} result_t;

endpackage

>>> design/ardp_core.sv
// Parser state and per-byte descriptor walk for the ATA return descriptor parser.
module ardp_core #(
	parameter int unsigned MAX_SENSE_BYTES = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        sense_byte,
	input  logic              final_byte,
	output ardp_pkg::result_t res
);

	localparam logic [ardp_pkg::POS_W-1:0] MaxPos = ardp_pkg::POS_W'(MAX_SENSE_BYTES);

	// Control state
	logic [ardp_pkg::POS_W-1:0] pos_q, pos_d;
	logic [ardp_pkg::OFF_W-1:0] next_off_q, next_off_d;
	logic                       format_ok_q, format_ok_d;
	logic                       matching_q, matching_d;
	logic                       done_q, done_d;
	// Captured descriptor fields
	logic [ardp_pkg::POS_W-1:0] desc_start_q, desc_start_d;
	logic [7:0]                 header_q, header_d;
	logic [7:0]                 err_q, err_d;
	logic [7:0]                 stat_q, stat_d;
	logic [ardp_pkg::LBA_W-1:0] lba_q, lba_d;

	logic [7:0]                 desc_off;
	logic [ardp_pkg::OFF_W:0]   len_pos;
	logic [7:0]                 resp_code;

	assign desc_off  = pos_q - desc_start_q;
	assign len_pos   = {1'b0, next_off_q} + {{ardp_pkg::OFF_W{1'b0}}, 1'b1};
	assign resp_code = sense_byte & ardp_pkg::RESP_CODE_MASK;

	// One byte of the walk
	always_comb begin
		pos_d        = pos_q;
		next_off_d   = next_off_q;
		format_ok_d  = format_ok_q;
		matching_d   = matching_q;
		done_d       = done_q;
		desc_start_d = desc_start_q;
		header_d     = header_q;
		err_d        = err_q;
		stat_d       = stat_q;
		lba_d        = lba_q;

		if (pos_q < MaxPos) begin
			pos_d = pos_q + 1'b1;
			if (pos_q == '0) begin
				format_ok_d = (resp_code == ardp_pkg::RESP_CODE_CUR) ||
				              (resp_code == ardp_pkg::RESP_CODE_DEF);
			end else if (format_ok_q && !done_q) begin
				if (matching_q) begin
					case (desc_off)
						ardp_pkg::OFF_ERROR:    err_d         = sense_byte;
						ardp_pkg::OFF_LBA_HI_C: lba_d[31:24]  = sense_byte;
						ardp_pkg::OFF_LBA_LO:   lba_d[7:0]    = sense_byte;
						ardp_pkg::OFF_LBA_HI_X: lba_d[39:32]  = sense_byte;
						ardp_pkg::OFF_LBA_MID:  lba_d[15:8]   = sense_byte;
						ardp_pkg::OFF_LBA_TOP:  lba_d[47:40]  = sense_byte;
						ardp_pkg::OFF_LBA_HIGH: lba_d[23:16]  = sense_byte;
						ardp_pkg::OFF_STATUS: begin
							stat_d     = sense_byte;
							done_d     = 1'b1;
							matching_d = 1'b0;
						end
						default: ;
					endcase
				end else if ({1'b0, pos_q} == next_off_q) begin
					// descriptor code byte
					desc_start_d = pos_q;
					header_d     = sense_byte;
				end else if ({2'b00, pos_q} == len_pos) begin
					// descriptor length byte: match or skip
					if (header_q == ardp_pkg::ATA_DESC_CODE &&
					    sense_byte >= ardp_pkg::ATA_DESC_MINLEN) begin
						matching_d = 1'b1;
						err_d      = '0;
						stat_d     = '0;
						lba_d      = '0;
					end else begin
						next_off_d = next_off_q + {1'b0, sense_byte} + ardp_pkg::OFF_W'(2);
					end
				end
			end
		end
	end

	// Result reflects the state after this byte; fields read zero without a match
	always_comb begin
		res.found  = done_d;
		res.status = done_d ? stat_d : '0;
		res.error  = done_d ? err_d : '0;
		res.lba    = done_d ? lba_d : '0;
	end

	// Control registers, cleared at the end of each buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			next_off_q  <= ardp_pkg::FIRST_DESC_OFF;
			format_ok_q <= 1'b0;
			matching_q  <= 1'b0;
			done_q      <= 1'b0;
		end else if (step) begin
			if (final_byte) begin
				pos_q       <= '0;
				next_off_q  <= ardp_pkg::FIRST_DESC_OFF;
				format_ok_q <= 1'b0;
				matching_q  <= 1'b0;
				done_q      <= 1'b0;
			end else begin
				pos_q       <= pos_d;
				next_off_q  <= next_off_d;
				format_ok_q <= format_ok_d;
				matching_q  <= matching_d;
				done_q      <= done_d;
			end
		end
	end

	// Captured fields; only read once the walk has set them
	always_ff @(posedge clk) begin
		if (step) begin
			desc_start_q <= desc_start_d;
			header_q     <= header_d;
			err_q        <= err_d;
			stat_q       <= stat_d;
			lba_q        <= lba_d;
		end
	end

endmodule

>>> design/ata_return_descriptor_parser_unit.sv
// Top level of the ATA return descriptor parser: input stage, parser and result register.
//
//  channel | signals                               | transaction
//  --------+---------------------------------------+------------------------------
//  in      | in_valid, in_stall, sense_byte,       | one sense byte, final flag
//          | final_byte                            | marks the buffer's last byte
//  out     | out_valid, out_stall, found,          | one parse result per buffer
//          | dev_status, dev_error, lba            |
//
// One byte per cycle unless stalled; a byte is parsed as it leaves the input stage.
// The result is registered as the final byte leaves the input stage.
// arst_n clears the input stage, the result register and the parser's walk state.
// out_stall stalls the input only while a final byte waits behind a held result.
module ata_return_descriptor_parser_unit #(
	parameter int unsigned MAX_SENSE_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  sense_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [7:0]  dev_status,
	output logic [7:0]  dev_error,
	output logic [47:0] lba
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              final_s1;
	logic              out_free;
	logic              adv_s1;
	logic              in_take;
	ardp_pkg::result_t res;
	ardp_pkg::result_t res_q;
	logic              out_valid_q;

	// Handshake: a non-final byte always moves on, a final one needs the result slot
	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && (!final_s1 || out_free);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_take  = in_valid && !in_stall;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1  <= sense_byte;
			final_s1 <= final_byte;
		end
	end

	ardp_core #(
		.MAX_SENSE_BYTES(MAX_SENSE_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv_s1),
		.sense_byte(byte_s1),
		.final_byte(final_s1),
		.res       (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && final_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && final_s1) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = res_q.found;
	assign dev_status = res_q.status;
	assign dev_error  = res_q.error;
	assign lba        = res_q.lba;

	// Fields read zero on a result without a match
	a_zero_when_missing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.found |-> res_q.status == '0 && res_q.error == '0 &&
		res_q.lba == '0)
		else $error("result fields nonzero without a match");

	// Input only stalls behind a final byte blocked by a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && final_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked final byte");

	// A new result only follows a final byte leaving the input stage
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv_s1 && final_s1))
		else $error("result raised without a final byte");

	// A held result is not overwritten
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> $stable(res_q))
		else $error("held result changed");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the ATA return descriptor parser unit.
`timescale 1ns / 100ps

module testbench;

	localparam int SENSE_LIMIT  = 32;
	localparam int RANDOM_BYTES = 900;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int REPORT_MAX   = 10;
	localparam int CALM_FROM    = 300;
	localparam int CALM_TO      = 700;

	// One sense byte transaction, with an optional hand-written expectation
	typedef struct packed {
		logic [7:0]        data;
		logic              last;
		logic              typed;
		ardp_pkg::result_t want;
	} sense_txn_t;

	localparam ardp_pkg::result_t NO_DESC = '{1'b0, 8'h00, 8'h00, 48'h0};
	localparam ardp_pkg::result_t ATA_HIT = '{1'b1, 8'h5A, 8'hA5, 48'h6655_4433_2211};
	localparam ardp_pkg::result_t DONT_CARE = '0;

	// Directed buffers: bad response codes, a full ATA descriptor, a short buffer
	localparam int DIRECTED_N = 26;
	localparam sense_txn_t DIRECTED [DIRECTED_N] = '{
		'{8'hFF, 1'b1, 1'b1, NO_DESC},   // 0xFF masks to 0x7F: not descriptor format
		'{8'h00, 1'b1, 1'b1, NO_DESC},
		'{8'hF2, 1'b0, 1'b0, DONT_CARE}, // 0xF2 masks to 0x72
		'{8'h00, 1'b0, 1'b0, DONT_CARE},
		'{8'hFF, 1'b0, 1'b0, DONT_CARE},
		'{8'h01, 1'b0, 1'b0, DONT_CARE},
		'{8'h80, 1'b0, 1'b0, DONT_CARE},
		'{8'h7F, 1'b0, 1'b0, DONT_CARE},
		'{8'hFE, 1'b0, 1'b0, DONT_CARE},
		'{8'h10, 1'b0, 1'b0, DONT_CARE},
		'{8'h09, 1'b0, 1'b0, DONT_CARE}, // descriptor code at byte 8
		'{8'h0C, 1'b0, 1'b0, DONT_CARE}, // minimum matching length
		'{8'hFF, 1'b0, 1'b0, DONT_CARE},
		'{8'hA5, 1'b0, 1'b0, DONT_CARE}, // error
		'{8'h00, 1'b0, 1'b0, DONT_CARE},
		'{8'hFF, 1'b0, 1'b0, DONT_CARE},
		'{8'h44, 1'b0, 1'b0, DONT_CARE}, // lba[31:24]
		'{8'h11, 1'b0, 1'b0, DONT_CARE}, // lba[7:0]
		'{8'h55, 1'b0, 1'b0, DONT_CARE}, // lba[39:32]
		'{8'h22, 1'b0, 1'b0, DONT_CARE}, // lba[15:8]
		'{8'h66, 1'b0, 1'b0, DONT_CARE}, // lba[47:40]
		'{8'h33, 1'b0, 1'b0, DONT_CARE}, // lba[23:16]
		'{8'hFF, 1'b0, 1'b0, DONT_CARE},
		'{8'h5A, 1'b1, 1'b1, ATA_HIT},   // status on the final byte
		'{8'h73, 1'b0, 1'b0, DONT_CARE}, // buffer ends before byte 8
		'{8'h09, 1'b1, 1'b1, NO_DESC}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  sense_byte = '0;
	logic        final_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        found;
	logic [7:0]  dev_status;
	logic [7:0]  dev_error;
	logic [47:0] lba;

	sense_txn_t        sense_q[$];
	ardp_pkg::result_t parse_q[$];
	sense_txn_t        cur_txn;
	int                cyc;
	int                quiet_cycles;
	int                mismatches = 0;

	// Parser shadow state
	int                         pos;
	logic [ardp_pkg::OFF_W-1:0] desc_next;
	logic [7:0]                 desc_base;
	logic [7:0]                 hdr_code;
	bit                         fmt_ok;
	bit                         in_ata_desc;
	bit                         ata_done;
	logic [7:0]                 cap_error;
	logic [7:0]                 cap_status;
	logic [ardp_pkg::LBA_W-1:0] cap_lba;

	ata_return_descriptor_parser_unit #(
		.MAX_SENSE_BYTES(SENSE_LIMIT)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sense_byte(sense_byte),
		.final_byte(final_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.found     (found),
		.dev_status(dev_status),
		.dev_error (dev_error),
		.lba       (lba)
	);

	always #2 clk = ~clk;

	task automatic clear_parser();
		pos         = 0;
		desc_next   = ardp_pkg::FIRST_DESC_OFF;
		desc_base   = '0;
		hdr_code    = '0;
		fmt_ok      = 1'b0;
		in_ata_desc = 1'b0;
		ata_done    = 1'b0;
		cap_error   = '0;
		cap_status  = '0;
		cap_lba     = '0;
	endtask

	// Shadow parser: takes one sense byte, yields a result on the final one
	task automatic parse_sense_byte(input logic [7:0] b, input logic last,
			output bit emit, output ardp_pkg::result_t res);
		int p;
		int off;
		p    = pos;
		emit = 1'b0;
		res  = '0;
		if (p < SENSE_LIMIT) begin
			pos = p + 1;
			if (p == 0) begin
				fmt_ok = ((b & ardp_pkg::RESP_CODE_MASK) == ardp_pkg::RESP_CODE_CUR) ||
					((b & ardp_pkg::RESP_CODE_MASK) == ardp_pkg::RESP_CODE_DEF);
			end else if (fmt_ok && !ata_done) begin
				if (in_ata_desc) begin
					off = p - int'(desc_base);
					case (off)
						ardp_pkg::OFF_ERROR:    cap_error = b;
						ardp_pkg::OFF_LBA_HI_C: cap_lba[31:24] = b;
						ardp_pkg::OFF_LBA_LO:   cap_lba[7:0] = b;
						ardp_pkg::OFF_LBA_HI_X: cap_lba[39:32] = b;
						ardp_pkg::OFF_LBA_MID:  cap_lba[15:8] = b;
						ardp_pkg::OFF_LBA_TOP:  cap_lba[47:40] = b;
						ardp_pkg::OFF_LBA_HIGH: cap_lba[23:16] = b;
						ardp_pkg::OFF_STATUS: begin
							cap_status  = b;
							ata_done    = 1'b1;
							in_ata_desc = 1'b0;
						end
						default: ;
					endcase
				end else if (p == int'(desc_next)) begin
					desc_base = p[7:0];
					hdr_code  = b;
				end else if (p == int'(desc_next) + 1) begin
					if (hdr_code == ardp_pkg::ATA_DESC_CODE &&
							b >= ardp_pkg::ATA_DESC_MINLEN) begin
						in_ata_desc = 1'b1;
						cap_error   = '0;
						cap_status  = '0;
						cap_lba     = '0;
					end else begin
						// nine-bit wrap of the walk offset
						desc_next = ardp_pkg::OFF_W'(desc_next + b + 2);
					end
				end
			end
		end
		if (last) begin
			emit = 1'b1;
			if (ata_done)
				res = '{1'b1, cap_status, cap_error, cap_lba};
			clear_parser();
		end
	endtask

	// Builds one random sense buffer, mostly well formed
	task automatic queue_random_buffer(output int n_bytes);
		logic [7:0] frame_q[$];
		logic [7:0] code;
		sense_txn_t t;
		int kind;
		int n_pre;
		int len;
		int cut;
		int mode;
		kind = $urandom_range(0, 99);
		if (kind < 85 && kind >= 70) begin
			// noise
			len = $urandom_range(1, 40);
			repeat (len) frame_q.push_back(8'($urandom));
		end else begin
			frame_q.push_back({1'($urandom),
				($urandom_range(0, 1) ? ardp_pkg::RESP_CODE_CUR[6:0] :
					ardp_pkg::RESP_CODE_DEF[6:0])});
			if (kind >= 85) begin
				// valid header, garbage after it
				len = $urandom_range(0, 39);
				repeat (len) frame_q.push_back(8'($urandom));
			end else begin
				repeat (7) frame_q.push_back(8'($urandom));
				n_pre = $urandom_range(0, 2);
				repeat (n_pre) begin
					code = ($urandom_range(0, 3) == 0) ? ardp_pkg::ATA_DESC_CODE :
						8'($urandom);
					if (code == ardp_pkg::ATA_DESC_CODE)
						len = $urandom_range(0, ardp_pkg::ATA_DESC_MINLEN - 1);
					else if ($urandom_range(0, 19) == 0)
						len = $urandom_range(20, 255);
					else
						len = $urandom_range(0, 8);
					frame_q.push_back(code);
					frame_q.push_back(8'(len));
					repeat (len)
						if (frame_q.size() < 44)
							frame_q.push_back(8'($urandom));
				end
				frame_q.push_back(ardp_pkg::ATA_DESC_CODE);
				if ($urandom_range(0, 3) == 0)
					frame_q.push_back(8'($urandom_range(ardp_pkg::ATA_DESC_MINLEN, 255)));
				else
					frame_q.push_back(8'($urandom_range(ardp_pkg::ATA_DESC_MINLEN,
						ardp_pkg::ATA_DESC_MINLEN + 2)));
				repeat (12 + $urandom_range(0, 4)) frame_q.push_back(8'($urandom));
				mode = $urandom_range(0, 99);
				if (mode < 15) begin
					// truncated
					cut = $urandom_range(1, frame_q.size());
					while (frame_q.size() > cut) void'(frame_q.pop_back());
				end else if (mode < 25) begin
					// runs past the position limit
					cut = SENSE_LIMIT + $urandom_range(1, 8);
					while (frame_q.size() < cut) frame_q.push_back(8'($urandom));
				end
			end
		end
		foreach (frame_q[i]) begin
			t.data  = frame_q[i];
			t.last  = (i == frame_q.size() - 1);
			t.typed = 1'b0;
			t.want  = '0;
			sense_q.push_back(t);
		end
		n_bytes = frame_q.size();
	endtask

	// Random idle decision shared by both channels
	function automatic bit take_break();
		if (cyc >= CALM_FROM && cyc < CALM_TO)
			return 1'b0;
		return $urandom_range(0, 99) < 6;
	endfunction

	// Stimulus, reset and end of run
	initial begin : main_flow
		int total;
		int n;
		arst_n = 1'b0;
		clear_parser();
		for (int i = 0; i < DIRECTED_N; i++)
			sense_q.push_back(DIRECTED[i]);
		total = DIRECTED_N;
		while (total < RANDOM_BYTES) begin
			queue_random_buffer(n);
			total += n;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (sense_q.size() != 0 || in_valid) @(posedge clk);
		while (parse_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Input channel: present bytes, predict on each accepted transaction
	always @(posedge clk) begin : drive_sense
		bit                fire;
		bit                emit;
		ardp_pkg::result_t res;
		if (arst_n) begin
			fire = in_valid && !in_stall;
			if (fire) begin
				parse_sense_byte(cur_txn.data, cur_txn.last, emit, res);
				if (emit)
					parse_q.push_back(cur_txn.typed ? cur_txn.want : res);
			end
			if (!in_valid || fire) begin
				if (sense_q.size() != 0 && !take_break()) begin
					cur_txn = sense_q.pop_front();
					in_valid   <= 1'b1;
					sense_byte <= cur_txn.data;
					final_byte <= cur_txn.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output channel backpressure
	always @(posedge clk) begin
		if (arst_n)
			out_stall <= take_break();
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin : check_results
		ardp_pkg::result_t got;
		ardp_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {found, dev_status, dev_error, lba};
			if (parse_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("ERROR: unexpected result found=%0b status=%h error=%h lba=%h",
						got.found, got.status, got.error, got.lba);
			end else begin
				want = parse_q.pop_front();
				if (got.found !== want.found || got.status !== want.status ||
						got.error !== want.error || got.lba !== want.lba) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("ERROR: found %0b/%0b status %h/%h error %h/%h lba %h/%h (exp/act)",
							want.found, got.found, want.status, got.status,
							want.error, got.error, want.lba, got.lba);
				end
			end
		end
	end

	// Cycle count and watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			cyc <= cyc + 1;
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end else begin
			cyc          <= 0;
			quiet_cycles <= 0;
		end
	end

endmodule
